[hdl/fgr_pkg.sv]
// shared types, constants and codes of the frame geometric remapper
package fgr_pkg;

    localparam int MAX_DIM_DEF = 512;
    localparam int ROW_W       = 9;
    localparam int COL_W       = 9;
    localparam int PIX_W       = 8;
    localparam int DIM_W       = 10;
    localparam int CFG_IDX_W   = 2;
    localparam int DIM_RESET   = 512;

    // rotation coefficient, cos 45 = sin 45 in q16
    localparam int ROT_Q16     = 46341;
    localparam int ROT_W       = 17;
    localparam int FRAC_W      = 16;

    localparam int Q_DEPTH     = 8;
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);
    localparam int INFL_W      = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd2;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_REQ  = 1'b1;

    typedef enum logic [1:0] {
        MODE_VFLIP     = 2'd0,
        MODE_HFLIP     = 2'd1,
        MODE_TRANSPOSE = 2'd2,
        MODE_ROTATE    = 2'd3
    } t_mode;

    typedef struct packed {
        logic             kind;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] pixel;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] out_pixel;
        logic             source_valid;
    } t_out_item;

    typedef struct packed {
        logic is_load;
        logic ok;
    } t_qctl;

endpackage

[hdl/fgr_front.sv]
// front pipeline: configuration, classification and source address computation
module fgr_front import fgr_pkg::*; #(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_take,
    input  t_in_item                        i_item,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]            i_cfg_index,
    input  logic [DIM_W-1:0]                i_cfg_data,
    output logic                            o_push,
    output t_qctl                           o_ctl,
    output logic [PIX_W-1:0]                o_pixel,
    output logic [2*$clog2(MAX_DIM)-1:0]    o_addr,
    output logic [INFL_W-1:0]               o_inflight
);

    localparam int CW = $clog2(MAX_DIM);
    localparam int DW = CW + 1;
    localparam int EW = ((DW > DIM_W) ? DW : DIM_W) + 2;
    localparam int FW = EW + 1;
    localparam int PW = FW + ROT_W;
    localparam int SW = PW + 1;
    localparam logic signed [ROT_W-1:0] KQ  = ROT_W'(ROT_Q16);
    localparam logic signed [SW-1:0]    RND = SW'((1 << FRAC_W) - 1);

    t_mode            r_mode;
    logic [DIM_W-1:0] r_rows;
    logic [DIM_W-1:0] r_cols;

    logic signed [EW-1:0] rows_e;
    logic signed [EW-1:0] cols_e;
    logic signed [EW-1:0] max_e;
    logic signed [EW-1:0] ox;
    logic signed [EW-1:0] oy;

    // stage 1: raw item
    logic     r_p1_v;
    t_in_item r_p1_item;

    // stage 2: classified, simple coordinates or rotation differences
    logic                 r_p2_v;
    logic                 r_p2_load;
    logic                 r_p2_ok;
    logic                 r_p2_rot;
    logic [PIX_W-1:0]     r_p2_pix;
    logic signed [EW-1:0] r_p2_sx;
    logic signed [EW-1:0] r_p2_sy;
    logic signed [FW-1:0] r_p2_dsum;
    logic signed [FW-1:0] r_p2_ddif;

    logic                 n_p2_load;
    logic                 n_p2_ok;
    logic                 n_p2_rot;
    logic signed [EW-1:0] n_p2_sx;
    logic signed [EW-1:0] n_p2_sy;
    logic signed [FW-1:0] n_p2_dsum;
    logic signed [FW-1:0] n_p2_ddif;
    logic signed [EW-1:0] rr;
    logic signed [EW-1:0] cc;
    logic signed [FW-1:0] nx;
    logic signed [FW-1:0] ny;

    // stage 3: products
    logic                 r_p3_v;
    logic                 r_p3_load;
    logic                 r_p3_ok;
    logic                 r_p3_rot;
    logic [PIX_W-1:0]     r_p3_pix;
    logic signed [EW-1:0] r_p3_sx;
    logic signed [EW-1:0] r_p3_sy;
    logic signed [PW-1:0] r_p3_px;
    logic signed [PW-1:0] r_p3_py;
    logic signed [PW-1:0] n_p3_px;
    logic signed [PW-1:0] n_p3_py;

    // stage 4: q16 source coordinates
    logic                 r_p4_v;
    logic                 r_p4_load;
    logic                 r_p4_ok;
    logic [PIX_W-1:0]     r_p4_pix;
    logic signed [SW-1:0] r_p4_x;
    logic signed [SW-1:0] r_p4_y;
    logic signed [SW-1:0] n_p4_x;
    logic signed [SW-1:0] n_p4_y;

    logic signed [SW-1:0] tx;
    logic signed [SW-1:0] ty;
    logic                 in_b;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_VFLIP;
            r_rows <= DIM_W'(DIM_RESET);
            r_cols <= DIM_W'(DIM_RESET);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MODE: r_mode <= t_mode'(i_cfg_data[1:0]);
                CFG_ROWS: r_rows <= i_cfg_data;
                CFG_COLS: r_cols <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // clamped frame size and rotation center
    always_comb begin
        max_e = EW'(MAX_DIM);
        if (r_rows == '0) begin
            rows_e = EW'(1);
        end else if (EW'(r_rows) > max_e) begin
            rows_e = max_e;
        end else begin
            rows_e = EW'(r_rows);
        end
        if (r_cols == '0) begin
            cols_e = EW'(1);
        end else if (EW'(r_cols) > max_e) begin
            cols_e = max_e;
        end else begin
            cols_e = EW'(r_cols);
        end
        ox = cols_e >>> 1;
        oy = rows_e >>> 1;
    end

    // classify
    always_comb begin
        rr        = EW'(r_p1_item.row);
        cc        = EW'(r_p1_item.col);
        nx        = FW'(cc) - FW'(ox);
        ny        = FW'(rr) - FW'(oy);
        n_p2_load = (r_p1_item.kind == KIND_LOAD);
        n_p2_rot  = 1'b0;
        n_p2_sx   = cc;
        n_p2_sy   = rr;
        n_p2_dsum = nx + ny;
        n_p2_ddif = ny - nx;
        if (n_p2_load) begin
            n_p2_ok = (rr < max_e) && (cc < max_e);
        end else begin
            n_p2_ok = (rr < rows_e) && (cc < cols_e);
            unique case (r_mode)
                MODE_VFLIP:     n_p2_sy = rows_e - EW'(1) - rr;
                MODE_HFLIP:     n_p2_sx = cols_e - EW'(1) - cc;
                MODE_TRANSPOSE: begin
                    n_p2_sx = rr;
                    n_p2_sy = cc;
                end
                MODE_ROTATE:    n_p2_rot = 1'b1;
            endcase
        end
    end

    assign n_p3_px = PW'(r_p2_dsum) * PW'(KQ);
    assign n_p3_py = PW'(r_p2_ddif) * PW'(KQ);

    // simple coordinates are carried as exact q16 values
    always_comb begin
        if (r_p3_rot) begin
            n_p4_x = SW'(r_p3_px) + (SW'(ox) <<< FRAC_W);
            n_p4_y = SW'(r_p3_py) + (SW'(oy) <<< FRAC_W);
        end else begin
            n_p4_x = SW'(r_p3_sx) <<< FRAC_W;
            n_p4_y = SW'(r_p3_sy) <<< FRAC_W;
        end
    end

    // truncate toward zero and bound check
    always_comb begin
        tx   = r_p4_x[SW-1] ? ((r_p4_x + RND) >>> FRAC_W) : (r_p4_x >>> FRAC_W);
        ty   = r_p4_y[SW-1] ? ((r_p4_y + RND) >>> FRAC_W) : (r_p4_y >>> FRAC_W);
        in_b = (tx >= 0) && (tx < SW'(cols_e)) && (ty >= 0) && (ty < SW'(rows_e));
    end

    assign o_push        = r_p4_v;
    assign o_ctl.is_load = r_p4_load;
    assign o_ctl.ok      = r_p4_load ? r_p4_ok : (r_p4_ok && in_b);
    assign o_pixel       = r_p4_pix;
    assign o_addr        = {ty[CW-1:0], tx[CW-1:0]};
    assign o_inflight    = INFL_W'(r_p1_v) + INFL_W'(r_p2_v) + INFL_W'(r_p3_v)
                         + INFL_W'(r_p4_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
            r_p4_v <= 1'b0;
        end else begin
            r_p1_v <= i_take;
            r_p2_v <= r_p1_v;
            r_p3_v <= r_p2_v;
            r_p4_v <= r_p3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_p1_item <= i_item;
        end
        r_p2_load <= n_p2_load;
        r_p2_ok   <= n_p2_ok;
        r_p2_rot  <= n_p2_rot;
        r_p2_pix  <= r_p1_item.pixel;
        r_p2_sx   <= n_p2_sx;
        r_p2_sy   <= n_p2_sy;
        r_p2_dsum <= n_p2_dsum;
        r_p2_ddif <= n_p2_ddif;
        r_p3_load <= r_p2_load;
        r_p3_ok   <= r_p2_ok;
        r_p3_rot  <= r_p2_rot;
        r_p3_pix  <= r_p2_pix;
        r_p3_sx   <= r_p2_sx;
        r_p3_sy   <= r_p2_sy;
        r_p3_px   <= n_p3_px;
        r_p3_py   <= n_p3_py;
        r_p4_load <= r_p3_load;
        r_p4_ok   <= r_p3_ok;
        r_p4_pix  <= r_p3_pix;
        r_p4_x    <= n_p4_x;
        r_p4_y    <= n_p4_y;
    end

endmodule

[hdl/fgr_queue.sv]
// short queue between the front pipeline and the frame store side
module fgr_queue import fgr_pkg::*; #(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  t_qctl                           i_ctl,
    input  logic [PIX_W-1:0]                i_pixel,
    input  logic [2*$clog2(MAX_DIM)-1:0]    i_addr,
    input  logic                            i_pop,
    output logic                            o_valid,
    output t_qctl                           o_ctl,
    output logic [PIX_W-1:0]                o_pixel,
    output logic [2*$clog2(MAX_DIM)-1:0]    o_addr,
    output logic [Q_CNT_W-1:0]              o_count
);

    localparam int AW    = 2 * $clog2(MAX_DIM);
    localparam int PTR_W = $clog2(Q_DEPTH);

    t_qctl            r_ctl  [Q_DEPTH];
    logic [PIX_W-1:0] r_pix  [Q_DEPTH];
    logic [AW-1:0]    r_addr [Q_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [Q_CNT_W-1:0] r_cnt;
    logic             pop_ok;

    assign o_valid = (r_cnt != '0);
    assign pop_ok  = i_pop && o_valid;
    assign o_ctl   = r_ctl[r_rp];
    assign o_pixel = r_pix[r_rp];
    assign o_addr  = r_addr[r_rp];
    assign o_count = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PTR_W'(1);
            end
            if (pop_ok) begin
                r_rp <= r_rp + PTR_W'(1);
            end
            if (i_push && !pop_ok) begin
                r_cnt <= r_cnt + Q_CNT_W'(1);
            end else if (!i_push && pop_ok) begin
                r_cnt <= r_cnt - Q_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ctl[r_wp]  <= i_ctl;
            r_pix[r_wp]  <= i_pixel;
            r_addr[r_wp] <= i_addr;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt < Q_CNT_W'(Q_DEPTH)))
        else $error("queue push while full");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !pop_ok) |=> (r_cnt == $past(r_cnt) + Q_CNT_W'(1)))
        else $error("queue count missed a push");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wp == r_rp))
        else $error("queue pointers apart while empty");

endmodule

[hdl/fgr_back.sv]
// back end: frame store writes, reads and the result register
module fgr_back import fgr_pkg::*; #(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  t_qctl                           i_ctl,
    input  logic [PIX_W-1:0]                i_pixel,
    input  logic [2*$clog2(MAX_DIM)-1:0]    i_addr,
    output logic                            o_pop,
    output logic                            o_strobe,
    output t_out_item                       o_result
);

    localparam int AW = 2 * $clog2(MAX_DIM);

    logic [PIX_W-1:0] r_mem [2**AW];
    logic [PIX_W-1:0] r_rdata;
    logic             r_rd_v;
    logic             r_rd_ok;
    logic             r_strobe;
    t_out_item        r_res;

    assign o_pop    = i_valid;
    assign o_strobe = r_strobe;
    assign o_result = r_res;

    always_ff @(posedge i_clk) begin
        if (i_valid && i_ctl.is_load && i_ctl.ok) begin
            r_mem[i_addr] <= i_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_rd_v   <= i_valid && !i_ctl.is_load;
            r_strobe <= r_rd_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ok            <= i_ctl.ok;
        r_res.out_pixel    <= r_rd_ok ? r_rdata : '0;
        r_res.source_valid <= r_rd_ok;
    end

    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n, 2) && r_strobe |-> ($past(i_valid, 2) && !$past(i_ctl.is_load, 2)))
        else $error("result without a request transfer from the queue");

    a_zero_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && !r_res.source_valid) |-> (r_res.out_pixel == '0))
        else $error("nonzero pixel for a source outside the frame");

endmodule

[hdl/frame_geometric_remap.sv]
// frame remapper top level: front pipeline, queue and frame store back end
// a request reaches o_strobe through the front stages, the queue slot, the store read and the output register
// throughput: one item per clock while busy is low; four front stages, one queue slot, store read, output reg
// busy rises only when front stages plus queue hold Q_DEPTH items; the back end never stalls
// loads give no result; a store entry is undefined until a load writes it
// synchronous active-low reset clears control and sets mode 0 and a 512 x 512 frame
module frame_geometric_remap import fgr_pkg::*; #(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_in_item             i_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data,
    output logic                 o_strobe,
    output t_out_item            o_result
);

    localparam int AW    = 2 * $clog2(MAX_DIM);
    localparam int SUM_W = Q_CNT_W + 1;

    logic               take;
    logic               push;
    t_qctl              f_ctl;
    logic [PIX_W-1:0]   f_pixel;
    logic [AW-1:0]      f_addr;
    logic [INFL_W-1:0]  inflight;
    logic               q_valid;
    t_qctl              q_ctl;
    logic [PIX_W-1:0]   q_pixel;
    logic [AW-1:0]      q_addr;
    logic [Q_CNT_W-1:0] q_count;
    logic               pop;

    // every item in flight has a reserved queue slot
    assign busy = (SUM_W'(inflight) + SUM_W'(q_count)) >= SUM_W'(Q_DEPTH);
    assign take = start && !busy;

    fgr_front #(.MAX_DIM(MAX_DIM)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_item      (i_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_push      (push),
        .o_ctl       (f_ctl),
        .o_pixel     (f_pixel),
        .o_addr      (f_addr),
        .o_inflight  (inflight)
    );

    fgr_queue #(.MAX_DIM(MAX_DIM)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ctl   (f_ctl),
        .i_pixel (f_pixel),
        .i_addr  (f_addr),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_ctl   (q_ctl),
        .o_pixel (q_pixel),
        .o_addr  (q_addr),
        .o_count (q_count)
    );

    fgr_back #(.MAX_DIM(MAX_DIM)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_ctl    (q_ctl),
        .i_pixel  (q_pixel),
        .i_addr   (q_addr),
        .o_pop    (pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

[test/testbench.sv]
// self-checking testbench for the frame geometric remapper
module testbench;
    import fgr_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int STORE_SIZE = MAX_DIM_DEF * MAX_DIM_DEF;
    localparam int SETTLE_CYCLES = 12;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_in_item             i_item;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DIM_W-1:0]     i_cfg_data;
    logic                 o_strobe;
    t_out_item            o_result;

    // predictor state
    logic [PIX_W-1:0] frame_copy [0:STORE_SIZE-1];
    bit               loaded [0:STORE_SIZE-1];
    t_mode            cur_mode;
    int               cur_rows;
    int               cur_cols;

    t_out_item expected_pixels[$];
    t_out_item want;
    int        mismatches = 0;
    bit        idling_on;

    frame_geometric_remap u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    always #2 i_clk = ~i_clk;

    function automatic int dim_eff(input logic [DIM_W-1:0] v);
        if (v == '0) return 1;
        if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
        return int'(v);
    endfunction

    // source pixel of an output coordinate under the current mode
    function automatic bit source_of(input int row, input int col,
                                     output longint sy, output longint sx);
        longint ox, oy, nx, ny;
        sy = 0;
        sx = 0;
        if (row >= cur_rows || col >= cur_cols) return 1'b0;
        case (cur_mode)
            MODE_VFLIP: begin
                sy = cur_rows - 1 - row;
                sx = col;
            end
            MODE_HFLIP: begin
                sy = row;
                sx = cur_cols - 1 - col;
            end
            MODE_TRANSPOSE: begin
                sy = col;
                sx = row;
            end
            default: begin
                ox = cur_cols / 2;
                oy = cur_rows / 2;
                nx = col - ox;
                ny = row - oy;
                // signed division truncates toward zero
                sx = (nx * ROT_Q16 + ny * ROT_Q16 + ox * 65536) / 65536;
                sy = (ny * ROT_Q16 - nx * ROT_Q16 + oy * 65536) / 65536;
            end
        endcase
        return sx >= 0 && sx < cur_cols && sy >= 0 && sy < cur_rows;
    endfunction

    task automatic send_item(input t_in_item it);
        t_out_item res;
        longint    sy, sx;
        bit        ok;
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        if (it.kind == KIND_LOAD) begin
            frame_copy[int'(it.row) * MAX_DIM_DEF + int'(it.col)] = it.pixel;
            loaded[int'(it.row) * MAX_DIM_DEF + int'(it.col)] = 1'b1;
        end else begin
            ok = source_of(int'(it.row), int'(it.col), sy, sx);
            res.source_valid = ok;
            res.out_pixel = ok ? frame_copy[int'(sy) * MAX_DIM_DEF + int'(sx)] : '0;
            expected_pixels.push_back(res);
        end
        if (idling_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic load_pixel(input int row, input int col, input logic [PIX_W-1:0] pix);
        t_in_item it;
        it.kind  = KIND_LOAD;
        it.row   = row[ROW_W-1:0];
        it.col   = col[COL_W-1:0];
        it.pixel = pix;
        send_item(it);
    endtask

    // a request whose source was never loaded gets a load first
    task automatic request_pixel(input int row, input int col);
        t_in_item it;
        longint   sy, sx;
        if (source_of(row, col, sy, sx) && !loaded[int'(sy) * MAX_DIM_DEF + int'(sx)])
            load_pixel(int'(sy), int'(sx), PIX_W'($urandom));
        it.kind  = KIND_REQ;
        it.row   = row[ROW_W-1:0];
        it.col   = col[COL_W-1:0];
        it.pixel = PIX_W'($urandom);
        send_item(it);
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (expected_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_MODE: cur_mode = t_mode'(data[1:0]);
            CFG_ROWS: cur_rows = dim_eff(data);
            CFG_COLS: cur_cols = dim_eff(data);
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_frame(input t_mode m, input logic [DIM_W-1:0] rows_raw,
                             input logic [DIM_W-1:0] cols_raw);
        logic [DIM_W-1:0] mode_word;
        drain();
        // unused upper bits of the mode word carry noise
        mode_word = DIM_W'($urandom);
        mode_word[1:0] = m;
        write_reg(CFG_MODE, mode_word);
        write_reg(CFG_ROWS, rows_raw);
        write_reg(CFG_COLS, cols_raw);
    endtask

    task automatic test_defaults();
        load_pixel(0, 0, 8'h00);
        load_pixel(0, 511, 8'hFF);
        load_pixel(511, 0, 8'h5A);
        load_pixel(511, 511, 8'hA5);
        request_pixel(0, 0);
        request_pixel(511, 511);
        request_pixel(0, 511);
        request_pixel(511, 0);
    endtask

    task automatic test_modes();
        set_frame(MODE_HFLIP, 10'd512, 10'd512);
        request_pixel(0, 511);
        request_pixel(256, 256);
        set_frame(MODE_TRANSPOSE, 10'd512, 10'd512);
        request_pixel(511, 0);
        request_pixel(0, 511);
        set_frame(MODE_ROTATE, 10'd512, 10'd512);
        request_pixel(0, 511);
        request_pixel(256, 256);
        request_pixel(511, 0);
    endtask

    task automatic test_frame_edges();
        // non-square transpose runs off the frame
        set_frame(MODE_TRANSPOSE, 10'd3, 10'd7);
        request_pixel(0, 5);
        request_pixel(2, 2);
        request_pixel(3, 0);
        drain();
        write_reg(CFG_UNUSED, 10'h3FF);
        // zero rows act as one, oversize columns act as the store width
        set_frame(MODE_VFLIP, 10'd0, 10'd1023);
        request_pixel(1, 0);
        request_pixel(0, 511);
    endtask

    task automatic test_random(input int phases, input int per_phase);
        logic [DIM_W-1:0] dims [2];
        int               row, col;
        for (int p = 0; p < phases; p++) begin
            for (int d = 0; d < 2; d++) begin
                case ($urandom_range(0, 9))
                    0:       dims[d] = DIM_W'($urandom_range(0, 1));
                    1:       dims[d] = DIM_W'(MAX_DIM_DEF);
                    2:       dims[d] = DIM_W'($urandom_range(513, 1023));
                    default: dims[d] = DIM_W'($urandom_range(2, 24));
                endcase
            end
            if (p == phases - 1) idling_on = 1'b0;
            set_frame(t_mode'($urandom_range(0, 3)), dims[0], dims[1]);
            for (int n = 0; n < per_phase; n++) begin
                if ($urandom_range(0, 7) == 0) begin
                    row = $urandom_range(0, MAX_DIM_DEF - 1);
                    col = $urandom_range(0, MAX_DIM_DEF - 1);
                end else begin
                    row = $urandom_range(0, cur_rows - 1);
                    col = $urandom_range(0, cur_cols - 1);
                end
                if ($urandom_range(0, 9) < 3) load_pixel(row, col, PIX_W'($urandom));
                else request_pixel(row, col);
                // sender holds off until every result is back
                if (p == 1 && n == per_phase / 2) drain();
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (expected_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: pixel %0d valid %0d",
                             o_result.out_pixel, o_result.source_valid);
            end else begin
                want = expected_pixels.pop_front();
                if (o_result.out_pixel !== want.out_pixel ||
                    o_result.source_valid !== want.source_valid) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected pixel %0d valid %0d, got pixel %0d valid %0d",
                                 want.out_pixel, want.source_valid,
                                 o_result.out_pixel, o_result.source_valid);
                end
            end
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_item      <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_MODE;
        i_cfg_data  <= '0;
        cur_mode  = MODE_VFLIP;
        cur_rows  = DIM_RESET;
        cur_cols  = DIM_RESET;
        idling_on = 1'b1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_defaults();
        test_modes();
        test_frame_edges();
        test_random(10, 40);
        drain();
        if (mismatches == 0 && expected_pixels.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

[files.f]
hdl/fgr_pkg.sv
hdl/fgr_front.sv
hdl/fgr_queue.sv
hdl/fgr_back.sv
hdl/frame_geometric_remap.sv
test/testbench.sv
